[rtl/ncf_pkg.sv]
package ncf_pkg;

  localparam int FracBits = 28;
  localparam int WordW    = FracBits + 4;
  localparam int ProdW    = 2 * WordW;
  localparam int DivW     = 2 * FracBits + 4;
  localparam int DivCntW  = $clog2(DivW);
  localparam int MaxDim   = 4096;
  localparam int DimW     = 13;
  localparam int WideW    = 48;

  typedef logic signed [WordW-1:0] q_t;

  localparam q_t QMax = {1'b0, {(WordW-1){1'b1}}};
  localparam q_t QMin = {1'b1, {(WordW-1){1'b0}}};
  localparam q_t QOne = q_t'(64'd1 << FracBits);
  localparam q_t QHalf = q_t'(64'd1 << (FracBits - 1));
  localparam q_t Thresh = q_t'(((64'd1 << FracBits) + 64'd500000) / 64'd1000000);
  localparam logic [63:0] Sqrt3K = 64'd3719550787;
  localparam q_t Sqrt3Half = q_t'((Sqrt3K + (64'd1 << (31 - FracBits))) >> (32 - FracBits));

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [31:0]     divisor;
  } div_req_t;

  function automatic q_t sat_q(input logic signed [WordW+1:0] v);
    if (v[WordW+1:WordW-1] != 3'b000 && v[WordW+1:WordW-1] != 3'b111) begin
      return v[WordW+1] ? QMin : QMax;
    end
    return v[WordW-1:0];
  endfunction

  function automatic q_t add_q(input q_t a, input q_t b);
    logic signed [WordW+1:0] s;
    s = (WordW+2)'(a) + (WordW+2)'(b);
    return sat_q(s);
  endfunction

  function automatic q_t sub_q(input q_t a, input q_t b);
    logic signed [WordW+1:0] s;
    s = (WordW+2)'(a) - (WordW+2)'(b);
    return sat_q(s);
  endfunction

  function automatic q_t tri_q(input q_t a);
    logic signed [WordW+1:0] s;
    s = (WordW+2)'(a) + (WordW+2)'(a) + (WordW+2)'(a);
    return sat_q(s);
  endfunction

  function automatic q_t sat_wide(input logic signed [WideW-1:0] v);
    if (v > $signed({{(WideW-WordW){1'b0}}, QMax})) begin
      return QMax;
    end
    if (v < $signed({{(WideW-WordW){1'b1}}, QMin})) begin
      return QMin;
    end
    return v[WordW-1:0];
  endfunction

  // magnitude product -> truncated, saturated fixed point
  function automatic q_t qconv(input logic [ProdW-1:0] m, input logic neg);
    logic [ProdW-1:0] r;
    logic             big;
    r   = m >> FracBits;
    big = |r[ProdW-1:WordW-1];
    if (big) begin
      return neg ? QMin : QMax;
    end
    return neg ? q_t'(-r[WordW-1:0]) : q_t'(r[WordW-1:0]);
  endfunction

  function automatic q_t qdiv_conv(input logic [DivW-1:0] quo, input logic neg);
    logic big;
    big = |quo[DivW-1:WordW-1];
    if (big) begin
      return neg ? QMin : QMax;
    end
    return neg ? q_t'(-quo[WordW-1:0]) : q_t'(quo[WordW-1:0]);
  endfunction

  function automatic logic [WordW-1:0] mag_q(input q_t a);
    return a[WordW-1] ? WordW'(-a) : WordW'(a);
  endfunction

  function automatic logic [16:0] base_of(input logic [1:0] root);
    unique case (root)
      2'd0:    return 17'd65536;
      2'd1:    return 17'd45875;
      2'd2:    return 17'd26214;
      default: return 17'd0;
    endcase
  endfunction

endpackage

[rtl/ncf_mul.sv]
module ncf_mul (
  input  ncf_pkg::q_t                    a_i,
  input  ncf_pkg::q_t                    b_i,
  output logic [ncf_pkg::ProdW-1:0]      mag_o,
  output logic                           neg_o
);

  logic [ncf_pkg::WordW-1:0] ma, mb;

  always_comb begin
    ma    = ncf_pkg::mag_q(a_i);
    mb    = ncf_pkg::mag_q(b_i);
    mag_o = ncf_pkg::ProdW'(ma) * ncf_pkg::ProdW'(mb);
    neg_o = a_i[ncf_pkg::WordW-1] ^ b_i[ncf_pkg::WordW-1];
  end

endmodule

[rtl/ncf_div.sv]
module ncf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ncf_pkg::div_req_t             req_i,
  output logic                          done_o,
  output logic [ncf_pkg::DivW-1:0]      quo_o
);

  logic                           busy_q, done_q;
  logic [ncf_pkg::DivCntW-1:0]    cnt_q;
  logic [ncf_pkg::DivW-1:0]       quo_q;
  logic [31:0]                    rem_q, dsr_q;
  logic [32:0]                    shifted, diff;

  always_comb begin
    shifted = {rem_q, quo_q[ncf_pkg::DivW-1]};
    diff    = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ncf_pkg::DivCntW'(ncf_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[ncf_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[ncf_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/newton_cubic_fractal_pixel_top.sv]
// Flow: input transaction, Newton steps, root choice and shade, then result transaction; a zero-derivative
// exit ends its step before the divisions.
// Each step: one loop check and products on the shared multiplier, then two divisions on
// the shared restoring divider; the shade takes one more division (skipped when max_iter
// is zero). Throughput: one pixel at a time.
// Reset: asynchronous active low; registers return to their defaults, no result pending.
module newton_cubic_fractal_pixel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // root_index[1:0], iterations[9:2], red[25:10],
                                      // green[41:26], blue[57:42], zero[63:58]
);

  localparam logic [2:0] RegCr = 3'd0, RegCi = 3'd1, RegStep = 3'd2,
                         RegIter = 3'd3, RegW = 3'd4, RegH = 3'd5;

  localparam logic [5:0] StIdle = 6'd0,  StInX = 6'd1,  StInY = 6'd2,  StInZ = 6'd3,
                         StLoop = 6'd4,  StM1 = 6'd5,   StM2 = 6'd6,   StM3 = 6'd7,
                         StM4 = 6'd8,    StM5 = 6'd9,   StM6 = 6'd10,  StM7 = 6'd11,
                         StM8 = 6'd12,   StM9 = 6'd13,  StM10 = 6'd14, StM11 = 6'd15,
                         StM12 = 6'd16,  StM13 = 6'd17, StM14 = 6'd18, StM15 = 6'd19,
                         StM16 = 6'd20,  StD1 = 6'd21,  StD2 = 6'd22,  StC1 = 6'd23,
                         StC2 = 6'd24,   StC3 = 6'd25,  StC4 = 6'd26,  StC5 = 6'd27,
                         StC6 = 6'd28,   StC7 = 6'd29,  StSh = 6'd30,  StShW = 6'd31,
                         StGr = 6'd32,   StOut = 6'd33;

  ncf_pkg::q_t                 cr_q, ci_q;
  logic [30:0]                 step_q;
  logic [7:0]                  miter_q;
  logic [ncf_pkg::DimW-1:0]    w_q, h_q;

  logic [5:0]                  state_q, state_d;
  logic [11:0]                 px_q, py_q;
  logic [7:0]                  n_q;
  logic [1:0]                  root_q;
  ncf_pkg::q_t                 zr_q, zi_q, zr2_q, zi2_q, fr_q, fi_q, dr_q, di_q;
  ncf_pkg::q_t                 den_q, nr_q, ni_q, g_q, t_q, tr_q, dmin_q;
  logic [15:0]                 red_q;
  logic                        ovalid_q;
  logic [63:0]                 odata_q;

  logic [ncf_pkg::ProdW-1:0]   mul_mag, pmag_q;
  logic                        mul_neg, pneg_q;
  ncf_pkg::q_t                 opa, opb, pq, dx0, dx1, dy1, dy2, dsum, ti;
  logic [ncf_pkg::DimW-1:0]    wc, hc;
  logic signed [13:0]          ddx, ddy;
  logic signed [ncf_pkg::WideW-1:0] raw, half_raw;
  ncf_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [ncf_pkg::DivW-1:0]    div_quo;
  logic [24:0]                 shade_num;
  logic [17:0]                 red3;
  logic [37:0]                 grn_prod;
  logic                        cfg_wr, in_acc;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q    <= '0;
      ci_q    <= '0;
      step_q  <= 31'd268435456;
      miter_q <= 8'd50;
      w_q     <= 13'd800;
      h_q     <= 13'd800;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegCr:   cr_q    <= pwdata;
        RegCi:   ci_q    <= pwdata;
        RegStep: step_q  <= pwdata[30:0];
        RegIter: miter_q <= pwdata[7:0];
        RegW:    w_q     <= pwdata[12:0];
        RegH:    h_q     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegCr:   prdata = cr_q;
      RegCi:   prdata = ci_q;
      RegStep: prdata = {1'b0, step_q};
      RegIter: prdata = {24'd0, miter_q};
      RegW:    prdata = {19'd0, w_q};
      RegH:    prdata = {19'd0, h_q};
      default: prdata = '0;
    endcase
  end

  // shared units
  ncf_mul u_mul (
    .a_i   (opa),
    .b_i   (opb),
    .mag_o (mul_mag),
    .neg_o (mul_neg)
  );

  always_ff @(posedge clk_i) begin
    pmag_q <= mul_mag;
    pneg_q <= mul_neg;
  end

  ncf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    wc       = (w_q > ncf_pkg::DimW'(ncf_pkg::MaxDim)) ? ncf_pkg::DimW'(ncf_pkg::MaxDim) : w_q;
    hc       = (h_q > ncf_pkg::DimW'(ncf_pkg::MaxDim)) ? ncf_pkg::DimW'(ncf_pkg::MaxDim) : h_q;
    ddx      = $signed({1'b0, px_q, 1'b0}) - $signed({1'b0, wc});
    ddy      = $signed({1'b0, py_q, 1'b0}) - $signed({1'b0, hc});
    raw      = pneg_q ? -$signed(pmag_q[ncf_pkg::WideW-1:0])
                      : $signed(pmag_q[ncf_pkg::WideW-1:0]);
    half_raw = raw >>> 1;
    pq       = ncf_pkg::qconv(pmag_q, pneg_q);
    dx0      = ncf_pkg::sub_q(zr_q, ncf_pkg::QOne);
    dx1      = ncf_pkg::add_q(zr_q, ncf_pkg::QHalf);
    dy1      = ncf_pkg::sub_q(zi_q, ncf_pkg::Sqrt3Half);
    dy2      = ncf_pkg::add_q(zi_q, ncf_pkg::Sqrt3Half);
    dsum     = ncf_pkg::add_q(t_q, pq);
    ti       = ncf_pkg::qdiv_conv(div_quo, ni_q[ncf_pkg::WordW-1]);
    shade_num = 25'(ncf_pkg::base_of(root_q)) * 25'(miter_q - n_q);
    red3     = 18'(red_q) * 18'd3;
    grn_prod = 38'(red3) * 38'd838861;
  end

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_q)
      StInX:        begin opa = ncf_pkg::q_t'(ddx); opb = {1'b0, step_q}; end
      StInY:        begin opa = ncf_pkg::q_t'(ddy); opb = {1'b0, step_q}; end
      StM1:         begin opa = zr_q;  opb = zr_q;  end
      StM2:         begin opa = zi_q;  opb = zi_q;  end
      StM3:         begin opa = zr_q;  opb = zi_q;  end
      StM4:         begin opa = zr2_q; opb = zr_q;  end
      StM5:         begin opa = zi2_q; opb = zi_q;  end
      StM6:         begin opa = zr2_q; opb = zi_q;  end
      StM7:         begin opa = zi2_q; opb = zr_q;  end
      StM8:         begin opa = dr_q;  opb = dr_q;  end
      StM9:         begin opa = di_q;  opb = di_q;  end
      StM10:        begin opa = fr_q;  opb = dr_q;  end
      StM11:        begin opa = fi_q;  opb = di_q;  end
      StM12:        begin opa = fi_q;  opb = dr_q;  end
      StM13:        begin opa = fr_q;  opb = di_q;  end
      StM14:        begin opa = fr_q;  opb = fr_q;  end
      StM15:        begin opa = fi_q;  opb = fi_q;  end
      StC1:         begin opa = dx0;   opb = dx0;   end
      StC2:         begin opa = zi_q;  opb = zi_q;  end
      StC3, StC5:   begin opa = dx1;   opb = dx1;   end
      StC4:         begin opa = dy1;   opb = dy1;   end
      StC6:         begin opa = dy2;   opb = dy2;   end
      default:      ;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      StM16: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ncf_pkg::mag_q(nr_q), {ncf_pkg::FracBits{1'b0}}};
        div_req.divisor  = den_q;
      end
      StD1: begin
        div_req.start    = div_done;
        div_req.dividend = {ncf_pkg::mag_q(ni_q), {ncf_pkg::FracBits{1'b0}}};
        div_req.divisor  = den_q;
      end
      StSh: begin
        div_req.start    = (miter_q != 8'd0);
        div_req.dividend = ncf_pkg::DivW'(shade_num);
        div_req.divisor  = {24'd0, miter_q};
      end
      default: ;
    endcase
  end

  // sequencer
  assign in_acc = s_axis_tvalid && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StInX;
      StInX:   state_d = StInY;
      StInY:   state_d = StInZ;
      StInZ:   state_d = StLoop;
      StLoop:  state_d = (n_q < miter_q) ? StM1 : StC1;
      StM1:    state_d = StM2;
      StM2:    state_d = StM3;
      StM3:    state_d = StM4;
      StM4:    state_d = StM5;
      StM5:    state_d = StM6;
      StM6:    state_d = StM7;
      StM7:    state_d = StM8;
      StM8:    state_d = StM9;
      StM9:    state_d = StM10;
      StM10:   state_d = StM11;
      StM11:   state_d = (den_q == '0) ? StC1 : StM12;
      StM12:   state_d = StM13;
      StM13:   state_d = StM14;
      StM14:   state_d = StM15;
      StM15:   state_d = StM16;
      StM16:   state_d = StD1;
      StD1:    if (div_done) state_d = StD2;
      StD2:    if (div_done) state_d = (g_q < ncf_pkg::Thresh) ? StC1 : StLoop;
      StC1:    state_d = StC2;
      StC2:    state_d = StC3;
      StC3:    state_d = StC4;
      StC4:    state_d = StC5;
      StC5:    state_d = StC6;
      StC6:    state_d = StC7;
      StC7:    state_d = StSh;
      StSh:    state_d = (miter_q == 8'd0) ? StGr : StShW;
      StShW:   if (div_done) state_d = StGr;
      StGr:    state_d = StOut;
      StOut:   if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      n_q      <= '0;
      root_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StInZ: n_q <= '0;
        StD2:  if (div_done && !(g_q < ncf_pkg::Thresh)) n_q <= n_q + 1'b1;
        StC3:  root_q <= 2'd0;
        StC5:  if (dsum < dmin_q) root_q <= 2'd1;
        StC7:  if (dsum < dmin_q) root_q <= 2'd2;
        StGr:  ovalid_q <= 1'b1;
        StOut: if (m_axis_tready) ovalid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_acc) begin
        px_q <= s_axis_tdata[11:0];
        py_q <= s_axis_tdata[23:12];
      end
      StInY: zr_q <= ncf_pkg::sat_wide(ncf_pkg::WideW'(cr_q) + half_raw);
      StInZ: zi_q <= ncf_pkg::sat_wide(ncf_pkg::WideW'(ci_q) - half_raw);
      StM2, StM5, StM7, StM9, StM11, StM13, StM15, StC2, StC4, StC6: t_q <= pq;
      StM3:  zr2_q <= ncf_pkg::sub_q(t_q, pq);
      StM4:  zi2_q <= ncf_pkg::add_q(pq, pq);
      StM6: begin
        fr_q <= ncf_pkg::sub_q(ncf_pkg::sub_q(t_q, pq), ncf_pkg::QOne);
        dr_q <= ncf_pkg::tri_q(zr2_q);
        di_q <= ncf_pkg::tri_q(zi2_q);
      end
      StM8:  fi_q  <= dsum;
      StM10: den_q <= dsum;
      StM12: nr_q  <= dsum;
      StM14: ni_q  <= ncf_pkg::sub_q(t_q, pq);
      StM16: g_q   <= dsum;
      StD1:  if (div_done) tr_q <= ncf_pkg::qdiv_conv(div_quo, nr_q[ncf_pkg::WordW-1]);
      StD2:  if (div_done) begin
        zr_q <= ncf_pkg::sub_q(zr_q, tr_q);
        zi_q <= ncf_pkg::sub_q(zi_q, ti);
      end
      StC3:  dmin_q <= dsum;
      StC5:  if (dsum < dmin_q) dmin_q <= dsum;
      StSh:  if (miter_q == 8'd0) begin
        red_q <= (ncf_pkg::base_of(root_q) > 17'd65535) ? 16'hFFFF
                                                        : 16'(ncf_pkg::base_of(root_q));
      end
      StShW: if (div_done) begin
        red_q <= (|div_quo[ncf_pkg::DivW-1:16]) ? 16'hFFFF : div_quo[15:0];
      end
      StGr:  odata_q <= {6'd0, red_q, grn_prod[37:22], red_q, n_q, root_q};
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

[rtl/ncf_checker.sv]
module ncf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("root index out of range");

  a_blue_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[57:42] == m_axis_tdata[25:10]))
    else $error("blue differs from red");

endmodule

bind newton_cubic_fractal_pixel_top ncf_checker u_ncf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[sim/ncf_tb_pkg.sv]
package ncf_tb_pkg;

  typedef enum logic [4:0] {
    RegCenterReal = 5'd0,
    RegCenterImag = 5'd4,
    RegPixelStep  = 5'd8,
    RegMaxIter    = 5'd12,
    RegWidth      = 5'd16,
    RegHeight     = 5'd20
  } ncf_reg_e;

  typedef struct packed {
    logic [1:0]  root;
    logic [7:0]  iters;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } shade_t;

endpackage

[sim/newton_cubic_fractal_pixel_checker.sv]
module newton_cubic_fractal_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMaxL  = 64'sd2147483647;
  localparam longint QMinL  = -64'sd2147483648;
  localparam longint QOneL  = 64'sd268435456;
  localparam longint QHalfL = 64'sd134217728;
  localparam longint ThreshL = (64'sd268435456 + 64'sd500000) / 64'sd1000000;
  localparam longint Sqrt3HalfL = (64'sd3719550787 + 64'sd8) >>> 4;

  longint center_re, center_im, step, iter_lim, width, height;
  ncf_tb_pkg::shade_t shade_q[$];
  int     errors = 0;
  int     results = 0;

  function automatic longint clamp_q(longint v);
    if (v > QMaxL) return QMaxL;
    if (v < QMinL) return QMinL;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint unsigned ua, ub, r;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    r   = (ua * ub) >> 28;
    if (r > 64'd2147483648) r = 64'd2147483648;
    return clamp_q(neg ? -longint'(r) : longint'(r));
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint unsigned un, ud, q;
    if (d == 0) return 0;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = (un << 28) / ud;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return clamp_q(((n < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint root_dist(longint zr, longint zi, longint rr, longint ri);
    longint dx, dy;
    dx = clamp_q(zr - rr);
    dy = clamp_q(zi - ri);
    return clamp_q(fmul(dx, dx) + fmul(dy, dy));
  endfunction

  function automatic ncf_tb_pkg::shade_t shade_pixel(longint x, longint y);
    ncf_tb_pkg::shade_t res;
    longint w, h, zr, zi, zr2, zi2, zr3, zi3, fr, fi, dr, di, den, tr, ti, dmin, d;
    longint unsigned base, red, n;
    logic [1:0] root;
    w  = (width > 4096) ? 4096 : width;
    h  = (height > 4096) ? 4096 : height;
    zr = clamp_q(center_re + (((2 * x - w) * step) >>> 1));
    zi = clamp_q(center_im - (((2 * y - h) * step) >>> 1));
    n  = 0;
    while (n < iter_lim) begin
      zr2 = clamp_q(fmul(zr, zr) - fmul(zi, zi));
      zi2 = clamp_q(2 * fmul(zr, zi));
      zr3 = clamp_q(fmul(zr2, zr) - fmul(zi2, zi));
      zi3 = clamp_q(fmul(zr2, zi) + fmul(zi2, zr));
      fr  = clamp_q(zr3 - QOneL);
      fi  = zi3;
      dr  = clamp_q(3 * zr2);
      di  = clamp_q(3 * zi2);
      den = clamp_q(fmul(dr, dr) + fmul(di, di));
      if (den == 0) break;
      tr = fdiv(clamp_q(fmul(fr, dr) + fmul(fi, di)), den);
      ti = fdiv(clamp_q(fmul(fi, dr) - fmul(fr, di)), den);
      zr = clamp_q(zr - tr);
      zi = clamp_q(zi - ti);
      if (clamp_q(fmul(fr, fr) + fmul(fi, fi)) < ThreshL) break;
      n++;
    end
    root = 2'd0;
    dmin = root_dist(zr, zi, QOneL, 0);
    d = root_dist(zr, zi, -QHalfL, Sqrt3HalfL);
    if (d < dmin) begin
      dmin = d;
      root = 2'd1;
    end
    d = root_dist(zr, zi, -QHalfL, -Sqrt3HalfL);
    if (d < dmin) root = 2'd2;
    base = (root == 2'd0) ? 65536 : (root == 2'd1) ? 45875 : 26214;
    red  = (iter_lim == 0) ? base : base * (iter_lim - n) / iter_lim;
    if (red > 65535) red = 65535;
    res.root  = root;
    res.iters = n[7:0];
    res.red   = red[15:0];
    res.green = 16'((red * 3) / 5);
    res.blue  = red[15:0];
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re <= 0;
      center_im <= 0;
      step      <= 268435456;
      iter_lim  <= 50;
      width     <= 800;
      height    <= 800;
    end else if (psel && penable && pwrite && pready) begin
      case (ncf_tb_pkg::ncf_reg_e'(paddr))
        ncf_tb_pkg::RegCenterReal: center_re <= longint'($signed(pwdata));
        ncf_tb_pkg::RegCenterImag: center_im <= longint'($signed(pwdata));
        ncf_tb_pkg::RegPixelStep:  step      <= longint'(pwdata[30:0]);
        ncf_tb_pkg::RegMaxIter:    iter_lim  <= longint'(pwdata[7:0]);
        ncf_tb_pkg::RegWidth:      width     <= longint'(pwdata[12:0]);
        ncf_tb_pkg::RegHeight:     height    <= longint'(pwdata[12:0]);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    ncf_tb_pkg::shade_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[25:10],
             m_axis_tdata[41:26], m_axis_tdata[57:42]};
      results++;
      if (shade_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", m_axis_tdata);
      end else begin
        want = shade_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: root %0d/%0d iter %0d/%0d rgb %0d,%0d,%0d / %0d,%0d,%0d",
                     want.root, got.root, want.iters, got.iters, want.red, want.green,
                     want.blue, got.red, got.green, got.blue);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      shade_q.push_back(shade_pixel(longint'(s_axis_tdata[11:0]),
                                    longint'(s_axis_tdata[23:12])));
  end

  assign errors_o  = errors;
  assign pending_o = shade_q.size();
  assign results_o = results;

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 200000;
  localparam int Phases     = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [63:0] m_axis_tdata;
  int          errors, pending, results, items;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  int unsigned cur_w, cur_h;

  always #1 clk_i = ~clk_i;

  newton_cubic_fractal_pixel_top i_dut (.*);

  newton_cubic_fractal_pixel_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  task automatic reg_write(ncf_tb_pkg::ncf_reg_e addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_view(logic [31:0] cr, logic [31:0] ci, logic [30:0] st,
                          logic [7:0] mi, logic [12:0] w, logic [12:0] h);
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    reg_write(ncf_tb_pkg::RegCenterReal, cr);
    reg_write(ncf_tb_pkg::RegCenterImag, ci);
    reg_write(ncf_tb_pkg::RegPixelStep, {1'b0, st});
    reg_write(ncf_tb_pkg::RegMaxIter, {24'd0, mi});
    reg_write(ncf_tb_pkg::RegWidth, {19'd0, w});
    reg_write(ncf_tb_pkg::RegHeight, {19'd0, h});
    cur_w = (w == 0) ? 1 : (w > 4096 ? 4096 : w);
    cur_h = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    items++;
  endtask

  task automatic random_pixel();
    if ($urandom_range(0, 3) == 0) send_pixel(12'($urandom), 12'($urandom));
    else send_pixel(12'($urandom_range(0, cur_w - 1)), 12'($urandom_range(0, cur_h - 1)));
  endtask

  always @(negedge clk_i) begin
    if (!quiet && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned sz;
    items = 0;
    cur_w = 800;
    cur_h = 800;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: centre, exact root, corners, negative real axis
    send_pixel(12'd400, 12'd400);
    send_pixel(12'd401, 12'd400);
    send_pixel(12'd399, 12'd400);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    // saturated view, huge step, wide clamp, zero height
    set_view(32'h7fffffff, 32'h80000000, 31'h7fffffff, 8'd255, 13'h1fff, 13'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd1);
    // zero step, zero iteration limit
    set_view(32'h80000000, 32'h7fffffff, 31'd0, 8'd0, 13'd0, 13'd4096);
    send_pixel(12'd17, 12'd3000);
    send_pixel(12'd4095, 12'd0);
    // single iteration, minimal step and size
    set_view(32'hf0000000, 32'h00000000, 31'd1, 8'd1, 13'd1, 13'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    // point equidistant from the two complex roots, deep limit
    set_view(32'hf8000000, 32'h0, 31'h00100000, 8'd255, 13'd2, 13'd2);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd1);
    send_pixel(12'd0, 12'd4095);

    for (int p = 0; p < Phases; p++) begin
      sz = $urandom_range(1, 4096);
      if (p % 4 == 3) begin
        set_view($urandom, $urandom, 31'($urandom), 8'($urandom_range(1, 255)),
                 13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        for (int i = 0; i < 10; i++) random_pixel();
      end else begin
        set_view(32'($urandom_range(0, 32'h40000000)) - 32'h20000000,
                 32'($urandom_range(0, 32'h40000000)) - 32'h20000000,
                 31'((64'd1 << 30) / sz + $urandom_range(0, 255)),
                 8'($urandom_range(1, 40)), 13'(sz), 13'($urandom_range(1, 4096)));
        if (p == Phases - 2) quiet = 1'b1;
        for (int i = 0; i < 230; i++) random_pixel();
      end
    end

    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    $display("%0d pixels over %0d view settings, %0d results compared",
             items, Phases + 4, results);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
